// ===== rtl/pdmu_pkg.sv =====
// Package for the point distance metric unit: widths, register and metric codes,
// the tag that travels down the root pipeline, and the saturation helper.
// No dependencies.
`default_nettype none
package pdmu_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int COORD_BITS = 31;
  localparam int DIST_W     = 25;

  // |a - b| fits in COORD_BITS unsigned bits; sum of three squares in SUM_W
  localparam int DIFF_W = COORD_BITS;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int MAN_W  = DIFF_W + 2;
  localparam int WIDE_W = (COORD_BITS + 2 > DIST_W + 1) ? COORD_BITS + 2 : DIST_W + 1;

  localparam logic [WIDE_W-1:0] HALF =
    (FRAC_BITS == 0) ? '0 : WIDE_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic [ROOT_W-1:0] FMASK = ROOT_W'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam int ADDR_W = 3;

  localparam logic REG_METRIC    = 1'b0;
  localparam logic REG_THREE_DIM = 1'b1;

  localparam logic [1:0] METRIC_EUC_RND  = 2'd0;
  localparam logic [1:0] METRIC_MANHATTAN = 2'd1;
  localparam logic [1:0] METRIC_MAX_AXIS = 2'd2;
  localparam logic [1:0] METRIC_EUC_CEIL = 2'd3;

  // valid bit plus the non-Euclidean result, carried alongside the root
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] alt;
  } tag_t;

  function automatic logic [DIST_W-1:0] sat_dist(input logic [WIDE_W-1:0] v);
    logic [WIDE_W-1:0] lim;
    lim = WIDE_W'(DIST_MAX);
    if (v > lim) begin
      sat_dist = DIST_MAX;
    end else begin
      sat_dist = v[DIST_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pdmu_isqrt.sv =====
// Pipelined integer square root: one result bit per stage, root and remainder.
// Depends on pdmu_pkg.
`default_nettype none
module pdmu_isqrt
  import pdmu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic [SUM_W-1:0]  rad_in,
  input  wire tag_t              tag_in,
  output logic      [ROOT_W-1:0] root,
  output logic      [REM_W-1:0]  rem,
  output tag_t                   tag_out
);

  logic [REM_W-1:0]  rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] root_q [ROOT_W+1];
  logic [SUM_W-1:0]  rad_q  [ROOT_W+1];
  logic [DIST_W-1:0] alt_q  [ROOT_W+1];
  logic [ROOT_W:0]   vld_q;

  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign rad_q[0]  = rad_in;
  assign alt_q[0]  = tag_in.alt;
  assign vld_q[0]  = tag_in.valid;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    // bring down the next two radicand bits, try (4r+1) at this weight
    assign rem_sh = {rem_q[k][REM_W-3:0], rad_q[k][SUM_W-1 -: 2]};
    assign trial  = {1'b0, root_q[k], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k+1] <= {root_q[k][ROOT_W-2:0], ge};
        rad_q[k+1]  <= {rad_q[k][SUM_W-3:0], 2'b00};
        alt_q[k+1]  <= alt_q[k];
      end
    end
  end

  assign root          = root_q[ROOT_W];
  assign rem           = rem_q[ROOT_W];
  assign tag_out.valid = vld_q[ROOT_W];
  assign tag_out.alt   = alt_q[ROOT_W];

`ifndef NO_ASSERTIONS
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    tag_out.valid |-> rem <= {2'b00, root, 1'b0})
    else $error("root remainder exceeds 2*root");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> vld_q[ROOT_W:1] == '0)
    else $error("root pipeline valid bits not cleared by reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld_q[ROOT_W:1]))
    else $error("root pipeline moved while stalled");
`endif

endmodule
`default_nettype wire

// ===== rtl/point_distance_metric_unit_top.sv =====
// Top level of the point distance metric unit: APB register file, difference,
// square and sum stages, root pipeline and rounding. Depends on pdmu_pkg, pdmu_isqrt.
`default_nettype none
// An accepted request reaches its distance at the output register through 36 register
// stages (diff, square, sum, 32 root stages, rounding; the accepting edge loads the diff
// stage). Throughput: one request per cycle; the 32-stage bit-per-stage root pipeline
// sets the depth, all stages advance together and stall as a whole when the output
// register is full and not taken.
// Reset (rst, synchronous): clears all valid bits, metric to Euclidean rounded, 2D mode.
module point_distance_metric_unit_top
  import pdmu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // APB configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COORD_BITS-1:0] first_x,
  input  wire logic [COORD_BITS-1:0] first_y,
  input  wire logic [COORD_BITS-1:0] first_z,
  input  wire logic [COORD_BITS-1:0] second_x,
  input  wire logic [COORD_BITS-1:0] second_y,
  input  wire logic [COORD_BITS-1:0] second_z,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [DIST_W-1:0]     distance
);

  // ---------------------------------------------------------------------------
  // Registers. Word address selects the register; low address bits are ignored.
  // ---------------------------------------------------------------------------
  logic [1:0] metric;
  logic       three_dim;
  logic       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      metric    <= METRIC_EUC_RND;
      three_dim <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_METRIC:    metric    <= pwdata[1:0];
        REG_THREE_DIM: three_dim <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_METRIC:    prdata = {30'd0, metric};
      REG_THREE_DIM: prdata = {31'd0, three_dim};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Global advance: every stage moves when the output register is free or taken.
  // ---------------------------------------------------------------------------
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                 input logic [COORD_BITS-1:0] b);
    logic [COORD_BITS:0] d;
    logic [COORD_BITS:0] m;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    m = d[COORD_BITS] ? (~d + 1'b1) : d;
    abs_diff = m[DIFF_W-1:0];
  endfunction

  // Stage 1: absolute per-axis differences; z forced to zero in 2D mode
  logic              s1_vld;
  logic [DIFF_W-1:0] s1_dx, s1_dy, s1_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx <= abs_diff(first_x, second_x);
      s1_dy <= abs_diff(first_y, second_y);
      s1_dz <= three_dim ? abs_diff(first_z, second_z) : '0;
    end
  end

  // Stage 2: squares, plus Manhattan / max-axis result
  logic              s2_vld;
  logic [SQ_W-1:0]   s2_sqx, s2_sqy, s2_sqz;
  logic [DIST_W-1:0] s2_alt;
  logic [MAN_W-1:0]  man_sum;
  logic [DIFF_W-1:0] max_xy, max_xyz;
  logic [WIDE_W-1:0] man_rnd, max_rnd;
  logic [DIST_W-1:0] alt_d;

  always_comb begin
    man_sum = MAN_W'(s1_dx) + MAN_W'(s1_dy) + MAN_W'(s1_dz);
    max_xy  = (s1_dx > s1_dy) ? s1_dx : s1_dy;
    max_xyz = (max_xy > s1_dz) ? max_xy : s1_dz;
    // rounding is monotonic, so round(max) equals max of rounded axes
    man_rnd = (WIDE_W'(man_sum) + HALF) >> FRAC_BITS;
    max_rnd = (WIDE_W'(max_xyz) + HALF) >> FRAC_BITS;
    alt_d   = (metric == METRIC_MANHATTAN) ? sat_dist(man_rnd) : sat_dist(max_rnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sqx <= SQ_W'(s1_dx) * SQ_W'(s1_dx);
      s2_sqy <= SQ_W'(s1_dy) * SQ_W'(s1_dy);
      s2_sqz <= SQ_W'(s1_dz) * SQ_W'(s1_dz);
      s2_alt <= alt_d;
    end
  end

  // Stage 3: sum of squares, exact
  logic             s3_vld;
  logic [SUM_W-1:0] s3_sum;
  logic [DIST_W-1:0] s3_alt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sum <= SUM_W'(s2_sqx) + SUM_W'(s2_sqy) + SUM_W'(s2_sqz);
      s3_alt <= s2_alt;
    end
  end

  // Root pipeline
  tag_t              s3_tag;
  tag_t              sq_tag;
  logic [ROOT_W-1:0] sq_root;
  logic [REM_W-1:0]  sq_rem;

  assign s3_tag.valid = s3_vld;
  assign s3_tag.alt   = s3_alt;

  pdmu_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .rad_in  (s3_sum),
    .tag_in  (s3_tag),
    .root    (sq_root),
    .rem     (sq_rem),
    .tag_out (sq_tag)
  );

  // Final stage: rounding of the root, metric select, saturation
  logic [WIDE_W-1:0] euc_rnd, euc_ceil;
  logic [DIST_W-1:0] dist_d;

  always_comb begin
    if (FRAC_BITS == 0) begin
      // no fraction bits: round up exactly when rem > r
      euc_rnd = WIDE_W'(sq_root) + WIDE_W'(REM_W'(sq_root) < sq_rem);
    end else begin
      euc_rnd = (WIDE_W'(sq_root) + HALF) >> FRAC_BITS;
    end
    euc_ceil = WIDE_W'(sq_root >> FRAC_BITS)
             + WIDE_W'(((sq_root & FMASK) != '0) || (sq_rem != '0));
    case (metric)
      METRIC_EUC_RND:  dist_d = sat_dist(euc_rnd);
      METRIC_EUC_CEIL: dist_d = sat_dist(euc_ceil);
      default:         dist_d = sq_tag.alt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sq_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && sq_tag.valid) begin
      distance <= dist_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_rst_clear: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_vld && !s2_vld && !s3_vld))
    else $error("front stages not cleared by reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable({s1_vld, s2_vld, s3_vld, out_valid}))
    else $error("front stages moved while stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_vld)
    else $error("accepted request did not enter stage 1");
`endif

endmodule
`default_nettype wire
